### rtl/pva_pkg.sv
`timescale 1ns / 1ps
package pva_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned DiffW  = CoordW + 1;
  localparam int unsigned NProdW = 2 * DiffW;
  localparam int unsigned NormW  = 64;
  localparam int unsigned CSumW  = 40;
  localparam int unsigned DProdW = CSumW + DiffW;
  localparam int unsigned TermW  = 106;
  localparam int unsigned FracSh = 30;
  localparam int unsigned QuotW  = TermW - FracSh;
  localparam int unsigned VolW   = 64;
  localparam int unsigned VSumW  = QuotW + 4;
  localparam int unsigned HalfSh = 32;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    logic       capture;
    logic       load_first;
    logic       n_mul;
    logic       n_close;
    logic       n_acc;
    logic       upd_vertex;
    logic       set_ovf;
    logic       d_mul;
    logic       d_acc;
    logic       half;
    logic [1:0] k;
    logic       div_start;
    logic       div_step;
    logic       vol_add;
    logic       clear_face;
    logic       clear_cell;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic count_full;
    logic count_ge3;
    logic fend;
    logic cend;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

### rtl/pva_ctrl.sv
`timescale 1ns / 1ps
module pva_ctrl import pva_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_VTX  = 11'b00000000010,
    S_NMUL = 11'b00000000100,
    S_NACC = 11'b00000001000,
    S_FEND = 11'b00000010000,
    S_DMUL = 11'b00000100000,
    S_DACC = 11'b00001000000,
    S_DIVI = 11'b00010000000,
    S_DIV  = 11'b00100000000,
    S_VADD = 11'b01000000000,
    S_CELL = 11'b10000000000
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] k_q, k_d;
  logic       close_q, close_d;
  logic       half_q, half_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    close_d = close_q;
    half_d  = half_q;
    cmd_o   = '0;
    cmd_o.k = k_q;
    cmd_o.half = half_q;
    cmd_o.n_close = close_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_VTX;
        end
      end
      S_VTX: begin
        if (sts_i.count_zero) begin
          cmd_o.load_first = 1'b1;
          state_d = S_FEND;
        end else if (!sts_i.count_full) begin
          k_d = 2'd0;
          close_d = 1'b0;
          state_d = S_NMUL;
        end else begin
          cmd_o.set_ovf = 1'b1;
          state_d = S_FEND;
        end
      end
      S_NMUL: begin
        cmd_o.n_mul = 1'b1;
        state_d = S_NACC;
      end
      S_NACC: begin
        cmd_o.n_acc = 1'b1;
        if (k_q == 2'd2) begin
          k_d = 2'd0;
          if (close_q) begin
            half_d = 1'b0;
            state_d = S_DMUL;
          end else begin
            cmd_o.upd_vertex = 1'b1;
            state_d = S_FEND;
          end
        end else begin
          k_d = k_q + 2'd1;
          state_d = S_NMUL;
        end
      end
      S_FEND: begin
        if (sts_i.fend || sts_i.cend) begin
          if (sts_i.count_ge3) begin
            k_d = 2'd0;
            close_d = 1'b1;
            state_d = S_NMUL;
          end else begin
            cmd_o.clear_face = 1'b1;
            state_d = S_CELL;
          end
        end else begin
          state_d = S_IDLE;
        end
      end
      S_DMUL: begin
        cmd_o.d_mul = 1'b1;
        state_d = S_DACC;
      end
      S_DACC: begin
        cmd_o.d_acc = 1'b1;
        if (!half_q) begin
          half_d = 1'b1;
          state_d = S_DMUL;
        end else begin
          half_d = 1'b0;
          if (k_q == 2'd2) begin
            state_d = S_DIVI;
          end else begin
            k_d = k_q + 2'd1;
            state_d = S_DMUL;
          end
        end
      end
      S_DIVI: begin
        cmd_o.div_start = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          state_d = S_VADD;
        end
      end
      S_VADD: begin
        cmd_o.vol_add = 1'b1;
        cmd_o.clear_face = 1'b1;
        state_d = S_CELL;
      end
      S_CELL: begin
        if (!sts_i.cend) begin
          state_d = S_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.clear_cell = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q     <= 2'd0;
      close_q <= 1'b0;
      half_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      close_q <= close_d;
      half_q  <= half_d;
    end
  end

  a_accept_to_vtx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_VTX)
    else $error("accepted item not taken to vertex step");

  a_div_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV && sts_i.div_done |=> state_q == S_VADD)
    else $error("divider finish not followed by volume add");

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_free)
    else $error("output register overwritten");

endmodule

### rtl/pva_dpath.sv
`timescale 1ns / 1ps
module pva_dpath import pva_pkg::*; #(
  parameter int unsigned MAX_FACE_VERTICES = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic signed [31:0]      vx_i,
  input  logic signed [31:0]      vy_i,
  input  logic signed [31:0]      vz_i,
  input  logic                    face_end_i,
  input  logic                    cell_end_i,
  input  cmd_t                    cmd_i,
  output sts_t                    sts_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [63:0]      volume_o,
  output logic                    overflow_o
);

  localparam int unsigned CntW = $clog2(MAX_FACE_VERTICES + 1);
  localparam int unsigned DivW = $clog2(6 * MAX_FACE_VERTICES + 1);
  localparam int unsigned DCntW = $clog2(QuotW);

  coord_t vin_q [3];
  logic   fend_q, cend_q;
  coord_t first_q [3];
  coord_t prev_q [3];
  logic signed [NormW-1:0] norm_q [3];
  logic signed [CSumW-1:0] csum_q [3];
  logic [CntW-1:0] cnt_q;
  logic signed [NProdW-1:0] nprod_q;
  logic signed [DProdW-1:0] dprod_q;
  logic signed [TermW-1:0] term_q;
  logic [QuotW-1:0] dq_q;
  logic [DivW-1:0] drem_q;
  logic [DCntW-1:0] dcnt_q;
  logic dneg_q;
  logic signed [VolW-1:0] vol_q;
  logic ovf_q;
  logic out_valid_q;
  logic signed [VolW-1:0] out_vol_q;
  logic out_ovf_q;

  coord_t a1, a2, b1, b2;
  logic signed [DiffW-1:0] dif, sm;
  logic signed [NormW+2:0] nsum;
  logic nsum_fit;
  logic signed [CSumW-1:0] csel;
  logic signed [NormW-1:0] nsel;
  logic signed [DiffW-1:0] dop;
  logic signed [TermW-1:0] dext;
  logic [QuotW-1:0] sar;
  logic [DivW:0] r2, dvs;
  logic ge;
  logic [QuotW-1:0] qf;
  logic signed [VSumW-1:0] vsum;
  logic vsum_fit;

  always_comb begin
    a1 = prev_q[1]; a2 = prev_q[2];
    b1 = cmd_i.n_close ? first_q[1] : vin_q[1];
    b2 = cmd_i.n_close ? first_q[2] : vin_q[2];
    case (cmd_i.k)
      2'd1: begin
        a1 = prev_q[2]; a2 = prev_q[0];
        b1 = cmd_i.n_close ? first_q[2] : vin_q[2];
        b2 = cmd_i.n_close ? first_q[0] : vin_q[0];
      end
      2'd2: begin
        a1 = prev_q[0]; a2 = prev_q[1];
        b1 = cmd_i.n_close ? first_q[0] : vin_q[0];
        b2 = cmd_i.n_close ? first_q[1] : vin_q[1];
      end
      default: ;
    endcase
  end

  assign dif = DiffW'(a1) - DiffW'(b1);
  assign sm  = DiffW'(a2) + DiffW'(b2);

  always_comb begin
    case (cmd_i.k)
      2'd1: begin csel = csum_q[1]; nsel = norm_q[1]; end
      2'd2: begin csel = csum_q[2]; nsel = norm_q[2]; end
      default: begin csel = csum_q[0]; nsel = norm_q[0]; end
    endcase
  end

  assign nsum = (NormW+3)'(nsel) + (NormW+3)'(nprod_q);
  assign nsum_fit = (nsum[NormW+2:NormW-1] == {4{nsum[NormW-1]}});

  assign dop  = cmd_i.half ? DiffW'($signed(nsel[NormW-1:HalfSh]))
                           : $signed({1'b0, nsel[HalfSh-1:0]});
  assign dext = cmd_i.half ? (TermW'(dprod_q) <<< HalfSh) : TermW'(dprod_q);

  assign sar = term_q[TermW-1:FracSh];
  assign dvs = (DivW+1)'(cnt_q) * (DivW+1)'(6);
  assign r2  = {drem_q, dq_q[QuotW-1]};
  assign ge  = (r2 >= dvs);

  assign qf = dneg_q ? ~dq_q : dq_q;
  assign vsum = VSumW'(vol_q) + VSumW'($signed(qf));
  assign vsum_fit = (vsum[VSumW-1:VolW-1] == {(VSumW-VolW+1){vsum[VolW-1]}});

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      vin_q[0] <= vx_i;
      vin_q[1] <= vy_i;
      vin_q[2] <= vz_i;
      fend_q   <= face_end_i;
      cend_q   <= cell_end_i;
    end
    if (cmd_i.n_mul) nprod_q <= dif * sm;
    if (cmd_i.d_mul) dprod_q <= csel * dop;
    for (int i = 0; i < 3; i++) begin
      if (cmd_i.load_first) begin
        first_q[i] <= vin_q[i];
        prev_q[i]  <= vin_q[i];
        csum_q[i]  <= CSumW'(vin_q[i]);
      end else if (cmd_i.upd_vertex) begin
        prev_q[i]  <= vin_q[i];
        csum_q[i]  <= csum_q[i] + CSumW'(vin_q[i]);
      end
    end
    if (cmd_i.div_start) begin
      dneg_q <= sar[QuotW-1];
      dq_q   <= sar[QuotW-1] ? ~sar : sar;
      drem_q <= '0;
      dcnt_q <= DCntW'(QuotW - 1);
    end else if (cmd_i.div_step) begin
      drem_q <= ge ? DivW'(r2 - dvs) : r2[DivW-1:0];
      dq_q   <= {dq_q[QuotW-2:0], ge};
      dcnt_q <= dcnt_q - DCntW'(1);
    end
    if (cmd_i.out_load) begin
      out_vol_q <= vol_q;
      out_ovf_q <= ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) norm_q[i] <= '0;
      cnt_q       <= '0;
      term_q      <= '0;
      vol_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.n_acc) begin
        if (nsum_fit) begin
          norm_q[cmd_i.k] <= nsum[NormW-1:0];
        end else begin
          norm_q[cmd_i.k] <= nsum[NormW+2] ? {1'b1, {(NormW-1){1'b0}}}
                                           : {1'b0, {(NormW-1){1'b1}}};
        end
      end
      if (cmd_i.d_acc) term_q <= term_q + dext;
      if (cmd_i.load_first || cmd_i.upd_vertex) cnt_q <= cnt_q + CntW'(1);
      if (cmd_i.clear_face) begin
        for (int i = 0; i < 3; i++) norm_q[i] <= '0;
        cnt_q  <= '0;
        term_q <= '0;
      end
      if (cmd_i.vol_add) begin
        if (vsum_fit) begin
          vol_q <= vsum[VolW-1:0];
        end else begin
          vol_q <= vsum[VSumW-1] ? {1'b1, {(VolW-1){1'b0}}} : {1'b0, {(VolW-1){1'b1}}};
        end
      end
      if (cmd_i.set_ovf || (cmd_i.n_acc && !nsum_fit) || (cmd_i.vol_add && !vsum_fit)) begin
        ovf_q <= 1'b1;
      end
      if (cmd_i.clear_cell) begin
        vol_q <= '0;
        ovf_q <= 1'b0;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.count_zero = (cnt_q == '0);
  assign sts_o.count_full = (cnt_q >= CntW'(MAX_FACE_VERTICES));
  assign sts_o.count_ge3  = (cnt_q >= CntW'(3));
  assign sts_o.fend       = fend_q;
  assign sts_o.cend       = cend_q;
  assign sts_o.div_done   = (dcnt_q == '0);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign volume_o    = out_vol_q;
  assign overflow_o  = out_ovf_q;

endmodule

### rtl/polyhedron_volume_accumulator_top.sv
`timescale 1ns / 1ps
// channel | handshake             | payload
// in      | in_valid_i/in_ready_o | vx_i vy_i vz_i face_end_i cell_end_i
// out     | out_valid_o/out_ready_i | volume_o overflow_o
// one 33x33 multiplier is shared over the three newell terms of each vertex;
// the first vertex of a face only loads the start point
// a face end with three or more vertices adds closing terms, six dot partial
// products and a one-bit-per-cycle floor divider by 6 * vertex count over 76
// quotient bits; a shorter face end adds no volume
// reset clears all control state and the newell, term and volume accumulators at once
// a cell end result waits in the output register; a second cell end stalls until it drains
module polyhedron_volume_accumulator_top import pva_pkg::*; #(
  parameter int unsigned MAX_FACE_VERTICES = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] vx_i,
  input  logic signed [31:0] vy_i,
  input  logic signed [31:0] vz_i,
  input  logic               face_end_i,
  input  logic               cell_end_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [63:0] volume_o,
  output logic               overflow_o
);

  cmd_t cmd;
  sts_t sts;

  pva_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pva_dpath #(
    .MAX_FACE_VERTICES (MAX_FACE_VERTICES)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .vx_i        (vx_i),
    .vy_i        (vy_i),
    .vz_i        (vz_i),
    .face_end_i  (face_end_i),
    .cell_end_i  (cell_end_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .volume_o    (volume_o),
    .overflow_o  (overflow_o)
  );

endmodule

### sim/tb_polyhedron_volume_accumulator_top.sv
`timescale 1ns / 1ps
module tb_polyhedron_volume_accumulator_top import pva_pkg::*; ();

  localparam int unsigned MaxFaceVerts = 64;
  localparam int unsigned CycleLimit   = 1000000;
  localparam int unsigned DrainCycles  = 300;

  typedef struct {
    coord_t x, y, z;
    logic   fe, ce;
    bit     hold;
  } vertex_t;

  typedef struct {
    logic signed [63:0] vol;
    logic               ovf;
  } cell_vol_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, face_end_i, cell_end_i;
  coord_t vx_i, vy_i, vz_i;
  logic out_valid_o, out_ready_i, overflow_o;
  logic signed [63:0] volume_o;

  polyhedron_volume_accumulator_top #(.MAX_FACE_VERTICES(MaxFaceVerts)) i_dut (.*);

  vertex_t   vertex_q[$];
  cell_vol_t cell_vol_q[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned accepted = 0;
  int unsigned idle_pct = 8;

  // predictor state
  coord_t             first_v[3], prev_v[3];
  logic signed [63:0] newell_acc[3], coord_acc[3];
  int unsigned        face_verts;
  logic signed [63:0] vol_acc;
  bit                 ovf_flag;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic signed [63:0] sat_accum(input logic signed [63:0] acc,
                                                   input logic signed [127:0] x);
    logic signed [127:0] s;
    s = acc;
    s = s + x;
    if (s > 128'sh7FFFFFFFFFFFFFFF) begin
      ovf_flag = 1'b1;
      return 64'sh7FFFFFFFFFFFFFFF;
    end
    if (s < -128'sh8000000000000000) begin
      ovf_flag = 1'b1;
      return 64'sh8000000000000000;
    end
    return s[63:0];
  endfunction

  function automatic void newell_add(input coord_t bx, input coord_t by, input coord_t bz);
    coord_t b[3];
    logic signed [32:0] d, s;
    logic signed [127:0] p;
    int i1, i2;
    b[0] = bx; b[1] = by; b[2] = bz;
    for (int k = 0; k < 3; k++) begin
      i1 = (k + 1) % 3;
      i2 = (k + 2) % 3;
      d = prev_v[i1] - b[i1];
      s = prev_v[i2] + b[i2];
      p = d * s;
      newell_acc[k] = sat_accum(newell_acc[k], p);
    end
  endfunction

  function automatic void clear_face_state();
    for (int k = 0; k < 3; k++) begin
      first_v[k] = '0; prev_v[k] = '0; newell_acc[k] = '0; coord_acc[k] = '0;
    end
    face_verts = 0;
  endfunction

  function automatic void predict_volume(input vertex_t v);
    coord_t c[3];
    logic signed [127:0] t, dv, q, r;
    cell_vol_t res;
    c[0] = v.x; c[1] = v.y; c[2] = v.z;
    if (face_verts == 0) begin
      for (int k = 0; k < 3; k++) begin
        first_v[k] = c[k]; prev_v[k] = c[k]; coord_acc[k] = c[k];
      end
      face_verts = 1;
    end else if (face_verts < MaxFaceVerts) begin
      newell_add(c[0], c[1], c[2]);
      for (int k = 0; k < 3; k++) begin
        coord_acc[k] = coord_acc[k] + c[k];
        prev_v[k] = c[k];
      end
      face_verts++;
    end else begin
      ovf_flag = 1'b1;
    end
    if (v.fe || v.ce) begin
      if (face_verts >= 3) begin
        newell_add(first_v[0], first_v[1], first_v[2]);
        t = '0;
        for (int k = 0; k < 3; k++) t = t + coord_acc[k] * newell_acc[k];
        t = t >>> 30;
        dv = 6 * face_verts;
        q = t / dv;
        r = t % dv;
        if (r != 0 && t < 0) q = q - 1;
        vol_acc = sat_accum(vol_acc, q);
      end
      clear_face_state();
    end
    if (v.ce) begin
      res.vol = vol_acc;
      res.ovf = ovf_flag;
      cell_vol_q = {cell_vol_q, res};
      vol_acc = '0;
      ovf_flag = 1'b0;
    end
  endfunction

  function automatic coord_t rand_coord(input int mode);
    case (mode)
      0: return coord_t'($signed($urandom_range(0, 32'h3FFFFF)) - 32'sh200000);
      1: return coord_t'($urandom);
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'sh7FFFFFFF;
          1: return 32'sh80000000;
          2: return '0;
          default: return coord_t'($urandom);
        endcase
      end
    endcase
  endfunction

  function automatic void add_vertex(input coord_t x, input coord_t y, input coord_t z,
                                     input logic fe, input logic ce, input bit hold = 0);
    vertex_t v;
    v.x = x; v.y = y; v.z = z; v.fe = fe; v.ce = ce; v.hold = hold;
    vertex_q = {vertex_q, v};
  endfunction

  function automatic void add_face(input int n, input int mode, input bit last, input bit hold);
    for (int i = 0; i < n; i++) begin
      add_vertex(rand_coord(mode), rand_coord(mode), rand_coord(mode),
                 (i == n - 1) && !(last && $urandom_range(0, 1)), (i == n - 1) && last,
                 hold && i == 0);
    end
  endfunction

  function automatic void add_tetra(input coord_t lo, input coord_t hi);
    coord_t p[4][3];
    int f[4][3] = '{'{0, 2, 1}, '{0, 1, 3}, '{0, 3, 2}, '{1, 2, 3}};
    p[0] = '{lo, lo, lo}; p[1] = '{hi, lo, lo}; p[2] = '{lo, hi, lo}; p[3] = '{lo, lo, hi};
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 3; j++) begin
        add_vertex(p[f[i][j]][0], p[f[i][j]][1], p[f[i][j]][2],
                   j == 2 && i != 3, j == 2 && i == 3);
      end
    end
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      vx_i <= '0; vy_i <= '0; vz_i <= '0;
      face_end_i <= 1'b0; cell_end_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        vertex_t v;
        v.x = vx_i; v.y = vy_i; v.z = vz_i; v.fe = face_end_i; v.ce = cell_end_i; v.hold = 0;
        predict_volume(v);
        accepted++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (vertex_q.size() > 0 && $urandom_range(0, 99) >= idle_pct &&
            !(vertex_q[0].hold && cell_vol_q.size() != 0)) begin
          vertex_t n;
          n = vertex_q.pop_front();
          vx_i <= n.x; vy_i <= n.y; vz_i <= n.z;
          face_end_i <= n.fe; cell_end_i <= n.ce;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= $urandom_range(0, 99) >= idle_pct;
      if (out_valid_o && out_ready_i) begin
        if (cell_vol_q.size() == 0) begin
          $display("%0t: unexpected item volume=%0d overflow=%0b", $time, volume_o, overflow_o);
          errors++;
        end else begin
          cell_vol_t e;
          e = cell_vol_q.pop_front();
          if (volume_o !== e.vol) begin
            $display("%0t: volume expected %0d actual %0d", $time, e.vol, volume_o);
            errors++;
          end
          if (overflow_o !== e.ovf) begin
            $display("%0t: overflow expected %0b actual %0b", $time, e.ovf, overflow_o);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_polyhedron_volume_accumulator_top: FAIL");
      $finish;
    end
    idle_pct <= (accepted > 400 && accepted < 700) ? 0 : 8;
  end

  initial begin
    int nf, nv, mode;
    clear_face_state();
    vol_acc = '0;
    ovf_flag = 1'b0;
    rst_ni = 1'b0;

    // empty cell, short faces, cell end without face end, saturating extremes
    add_vertex(32'sh7FFFFFFF, 32'sh80000000, 32'sh00010000, 1'b0, 1'b1);
    add_vertex(32'sh00010000, 0, 0, 1'b1, 1'b0);
    add_vertex(0, 0, 0, 1'b0, 1'b0);
    add_vertex(0, 32'sh00010000, 0, 1'b1, 1'b0);
    add_vertex(32'shFFFFFFFF, 0, 0, 1'b0, 1'b1);
    add_tetra(0, 32'sh00010000);
    add_tetra(32'sh80000000, 32'sh7FFFFFFF);

    // one face past the vertex limit, then random cells
    add_face(MaxFaceVerts + 2, 0, 1'b1, 1'b0);
    while (vertex_q.size() < 1250) begin
      nf = $urandom_range(1, 6);
      mode = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 2);
      for (int f = 0; f < nf; f++) begin
        case ($urandom_range(0, 19))
          0: nv = $urandom_range(1, 2);
          1: nv = (vertex_q.size() % 5 == 0) ? $urandom_range(MaxFaceVerts - 1, MaxFaceVerts + 2)
                                             : $urandom_range(9, 16);
          default: nv = $urandom_range(3, 8);
        endcase
        add_face(nv, mode, f == nf - 1, f == 0 && vertex_q.size() > 600 &&
                 vertex_q.size() < 620);
      end
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (vertex_q.size() == 0 && !in_valid_i);
    wait (cell_vol_q.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_polyhedron_volume_accumulator_top: PASS");
    end else begin
      $display("tb_polyhedron_volume_accumulator_top: FAIL");
    end
    $finish;
  end

endmodule
